// File: sv/gf_pm_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// GF(p^m) arithmetic unit assertion macros
// Shorthand for clocked implications with reset disable.
// ----------------------------------------------------------------------------
`ifndef GF_PM_ARITHMETIC_UNIT_ASSERT_SVH
`define GF_PM_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GFPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GFPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gfpm_pkg.sv
// ----------------------------------------------------------------------------
// gfpm_pkg
// Shared types, register codes and the modular reduction step function.
// ----------------------------------------------------------------------------
`default_nettype none

package gfpm_pkg;

  localparam int CW                 = 8;   // coefficient width, holds 0..p-1
  localparam int MODW               = 32;  // working width of reduction steps
  localparam int WORD_W             = 64;
  localparam int CFG_IDX_W          = 2;
  localparam int DEG_W              = 4;
  localparam int DEFAULT_MAX_DEGREE = 8;
  localparam int DEFAULT_DIGIT_BITS = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RCOEF   = 2'd2;

  localparam logic [CW-1:0]     MODULUS_RESET = 8'd2;
  localparam logic [DEG_W-1:0]  DEGREE_RESET  = 4'd1;
  localparam logic [WORD_W-1:0] RCOEF_RESET   = 64'd1;

  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_SCALE,
    CMD_ADD_INT,
    CMD_SUB_INT,
    CMD_NEG,
    CMD_EQUAL
  } cmd_e;

  // Restoring reduction: subtract p<<k for k from hi down to lo.
  function automatic logic [MODW-1:0] mod_steps(input logic [MODW-1:0] v,
                                                input logic [CW-1:0] p,
                                                input int hi,
                                                input int lo);
    logic [MODW-1:0] acc;
    logic [MODW-1:0] dec;
    acc = v;
    for (int k = MODW - 2; k >= 0; k--) begin
      dec = MODW'(p) << k;
      if (k <= hi && k >= lo && acc >= dec) begin
        acc = acc - dec;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: sv/gf_pm_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gf_pm_arithmetic_unit
// Throughput: one request per cycle; an output stall holds the whole pipe.
// Depth is set by the top-down fold of the product, four stages per fold.
// Reset clears the valid bits and loads modulus 2, degree 1, x^m = 1.
// ----------------------------------------------------------------------------
`default_nettype none

module gf_pm_arithmetic_unit #(
  parameter int MAX_DEGREE = gfpm_pkg::DEFAULT_MAX_DEGREE,
  parameter int DIGIT_BITS = gfpm_pkg::DEFAULT_DIGIT_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [gfpm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [gfpm_pkg::WORD_W-1:0]         cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [2:0]                          command_i,
  input  wire logic [gfpm_pkg::WORD_W-1:0]         operand_a_i,
  input  wire logic [gfpm_pkg::WORD_W-1:0]         operand_b_i,
  input  wire logic [gfpm_pkg::CW-1:0]             scalar_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [gfpm_pkg::WORD_W-1:0]              result_o,
  output logic                                     equal_o
);

  localparam int N       = MAX_DEGREE;
  localparam int Q       = 2 * N - 1;
  localparam int CW      = gfpm_pkg::CW;
  localparam int MODW    = gfpm_pkg::MODW;
  localparam int WORD_W  = gfpm_pkg::WORD_W;
  localparam int MW      = $clog2(N + 1);
  localparam int PROD_W  = 2 * CW;
  localparam int CONV_W  = PROD_W + $clog2(N);
  localparam int FOLD_W  = PROD_W + 1;
  localparam int DB_PER  = (DIGIT_BITS + 1) / 3;
  localparam int SC_PER  = (CW + 1) / 3;
  localparam int CV_PER  = (CONV_W + 1) / 3;
  localparam int FD_PER  = (FOLD_W + 1) / 3;
  localparam int RED_ST  = 3;
  localparam int ST_P    = RED_ST;
  localparam int ST_C    = ST_P + 1;
  localparam int ST_CM   = ST_C + 1;
  localparam int ST_F    = ST_CM + RED_ST;
  localparam int FOLD_ST = RED_ST + 1;
  localparam int NFOLD   = N - 1;
  localparam int LAT     = ST_F + FOLD_ST * NFOLD + 1;
  localparam int SD_N    = LAT - 1 - ST_P;

  typedef struct packed {
    logic                 mul;
    logic                 eq;
    logic [N-1:0][CW-1:0] early;
    logic [N-1:0][CW-1:0] rr;
  } side_t;

  // Configuration
  logic [CW-1:0]                  modulus_q;
  logic [gfpm_pkg::DEG_W-1:0]     degree_q;
  logic [WORD_W-1:0]              rcoef_q;
  logic [CW-1:0]                  p_eff;
  logic [MW-1:0]                  m_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= gfpm_pkg::MODULUS_RESET;
      degree_q  <= gfpm_pkg::DEGREE_RESET;
      rcoef_q   <= gfpm_pkg::RCOEF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gfpm_pkg::CFG_MODULUS: modulus_q <= cfg_data_i[CW-1:0];
        gfpm_pkg::CFG_DEGREE:  degree_q  <= cfg_data_i[gfpm_pkg::DEG_W-1:0];
        gfpm_pkg::CFG_RCOEF:   rcoef_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    p_eff = (modulus_q < CW'(2)) ? CW'(2) : modulus_q;
    if (degree_q == '0) begin
      m_eff = MW'(1);
    end else if (int'(degree_q) > N) begin
      m_eff = MW'(N);
    end else begin
      m_eff = MW'(degree_q);
    end
  end

  // Pipeline control
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Input digit reduction, three stages
  logic [DIGIT_BITS-1:0] ia_d [RED_ST][N];
  logic [DIGIT_BITS-1:0] ia_q [RED_ST][N];
  logic [DIGIT_BITS-1:0] ib_d [RED_ST][N];
  logic [DIGIT_BITS-1:0] ib_q [RED_ST][N];
  logic [DIGIT_BITS-1:0] ir_d [RED_ST][N];
  logic [DIGIT_BITS-1:0] ir_q [RED_ST][N];
  logic [CW-1:0]         is_d [RED_ST];
  logic [CW-1:0]         is_q [RED_ST];
  gfpm_pkg::cmd_e        icmd_q [RED_ST];

  always_comb begin
    logic [DIGIT_BITS-1:0] da;
    logic [DIGIT_BITS-1:0] db;
    logic [DIGIT_BITS-1:0] dr;
    // drop digits at and above the degree in use
    for (int k = 0; k < N; k++) begin
      if (k < int'(m_eff)) begin
        da = DIGIT_BITS'(operand_a_i >> (DIGIT_BITS * k));
        db = DIGIT_BITS'(operand_b_i >> (DIGIT_BITS * k));
        dr = DIGIT_BITS'(rcoef_q >> (DIGIT_BITS * k));
      end else begin
        da = '0;
        db = '0;
        dr = '0;
      end
      ia_d[0][k] = DIGIT_BITS'(gfpm_pkg::mod_steps(MODW'(da), p_eff,
                     DIGIT_BITS - 2, DIGIT_BITS - 1 - DB_PER));
      ib_d[0][k] = DIGIT_BITS'(gfpm_pkg::mod_steps(MODW'(db), p_eff,
                     DIGIT_BITS - 2, DIGIT_BITS - 1 - DB_PER));
      ir_d[0][k] = DIGIT_BITS'(gfpm_pkg::mod_steps(MODW'(dr), p_eff,
                     DIGIT_BITS - 2, DIGIT_BITS - 1 - DB_PER));
    end
    is_d[0] = CW'(gfpm_pkg::mod_steps(MODW'(scalar_i), p_eff, CW - 2, CW - 1 - SC_PER));
    for (int s = 1; s < RED_ST; s++) begin
      for (int k = 0; k < N; k++) begin
        ia_d[s][k] = DIGIT_BITS'(gfpm_pkg::mod_steps(MODW'(ia_q[s-1][k]), p_eff,
                       DIGIT_BITS - 2 - s * DB_PER, DIGIT_BITS - 1 - (s + 1) * DB_PER));
        ib_d[s][k] = DIGIT_BITS'(gfpm_pkg::mod_steps(MODW'(ib_q[s-1][k]), p_eff,
                       DIGIT_BITS - 2 - s * DB_PER, DIGIT_BITS - 1 - (s + 1) * DB_PER));
        ir_d[s][k] = DIGIT_BITS'(gfpm_pkg::mod_steps(MODW'(ir_q[s-1][k]), p_eff,
                       DIGIT_BITS - 2 - s * DB_PER, DIGIT_BITS - 1 - (s + 1) * DB_PER));
      end
      is_d[s] = CW'(gfpm_pkg::mod_steps(MODW'(is_q[s-1]), p_eff,
                  CW - 2 - s * SC_PER, CW - 1 - (s + 1) * SC_PER));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ia_q      <= ia_d;
      ib_q      <= ib_d;
      ir_q      <= ir_d;
      is_q      <= is_d;
      icmd_q[0] <= gfpm_pkg::cmd_e'(command_i);
      for (int s = 1; s < RED_ST; s++) begin
        icmd_q[s] <= icmd_q[s-1];
      end
    end
  end

  // Operand select, element-wise ops, reversed partial products
  logic [PROD_W-1:0] pt_d [N][N];
  logic [PROD_W-1:0] pt_q [N][N];
  side_t             side_d;
  side_t             sd_q [SD_N];

  always_comb begin
    logic [CW-1:0] ea [N];
    logic [CW-1:0] eb [N];
    logic [CW-1:0] er [N];
    logic [CW-1:0] x  [N];
    logic [CW-1:0] y  [N];
    logic [CW-1:0] xr [N];
    logic [CW-1:0] yr [N];
    logic [CW:0]   sum;
    logic          do_mul;
    logic          do_sub;
    logic          do_eq;
    logic          use_s;
    logic          zero_x;
    logic          same;
    do_mul = 1'b0;
    do_sub = 1'b0;
    do_eq  = 1'b0;
    use_s  = 1'b0;
    zero_x = 1'b0;
    case (icmd_q[RED_ST-1])
      gfpm_pkg::CMD_ADD:     ;
      gfpm_pkg::CMD_SUB:     do_sub = 1'b1;
      gfpm_pkg::CMD_MUL:     do_mul = 1'b1;
      gfpm_pkg::CMD_SCALE:   begin do_mul = 1'b1; use_s = 1'b1; end
      gfpm_pkg::CMD_ADD_INT: use_s = 1'b1;
      gfpm_pkg::CMD_SUB_INT: begin do_sub = 1'b1; use_s = 1'b1; end
      gfpm_pkg::CMD_NEG:     begin do_sub = 1'b1; zero_x = 1'b1; end
      gfpm_pkg::CMD_EQUAL:   do_eq = 1'b1;
      default:               do_eq = 1'b1;
    endcase
    same = 1'b1;
    for (int k = 0; k < N; k++) begin
      ea[k] = CW'(ia_q[RED_ST-1][k]);
      eb[k] = CW'(ib_q[RED_ST-1][k]);
      er[k] = CW'(ir_q[RED_ST-1][k]);
      if (ea[k] != eb[k]) begin
        same = 1'b0;
      end
    end
    for (int k = 0; k < N; k++) begin
      // negate is 0 - a, scalar forms put s on the constant term
      x[k] = zero_x ? '0 : ea[k];
      if (zero_x) begin
        y[k] = ea[k];
      end else if (use_s) begin
        y[k] = (k == 0) ? is_q[RED_ST-1] : '0;
      end else begin
        y[k] = eb[k];
      end
      if (do_sub) begin
        sum = {1'b0, x[k]} + {1'b0, p_eff} - {1'b0, y[k]};
      end else begin
        sum = {1'b0, x[k]} + {1'b0, y[k]};
      end
      if (sum >= {1'b0, p_eff}) begin
        sum = sum - {1'b0, p_eff};
      end
      side_d.early[k] = do_eq ? '0 : CW'(sum);
    end
    // reverse the low m coefficients so the fold indices stay fixed
    for (int i = 0; i < N; i++) begin
      xr[i] = '0;
      yr[i] = '0;
      side_d.rr[i] = '0;
      for (int j = 0; j < N; j++) begin
        if (i + j + 1 == int'(m_eff)) begin
          xr[i] = x[j];
          yr[i] = y[j];
          side_d.rr[i] = er[j];
        end
      end
    end
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        pt_d[i][j] = PROD_W'(xr[i]) * PROD_W'(yr[j]);
      end
    end
    side_d.mul = do_mul;
    side_d.eq  = do_eq && same;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q     <= pt_d;
      sd_q[0]  <= side_d;
      for (int g = 1; g < SD_N; g++) begin
        sd_q[g] <= sd_q[g-1];
      end
    end
  end

  // Convolution sums and their reduction
  logic [CONV_W-1:0] cs_d [Q];
  logic [CONV_W-1:0] cs_q [Q];
  logic [CONV_W-1:0] cq_d [RED_ST][Q];
  logic [CONV_W-1:0] cq_q [RED_ST][Q];
  logic [CW-1:0]     qin  [N][Q];

  always_comb begin
    for (int u = 0; u < Q; u++) begin
      cs_d[u] = '0;
    end
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        cs_d[i+j] = cs_d[i+j] + CONV_W'(pt_q[i][j]);
      end
    end
  end

  always_comb begin
    for (int u = 0; u < Q; u++) begin
      cq_d[0][u] = CONV_W'(gfpm_pkg::mod_steps(MODW'(cs_q[u]), p_eff,
                     CONV_W - 2, CONV_W - 1 - CV_PER));
    end
    for (int s = 1; s < RED_ST; s++) begin
      for (int u = 0; u < Q; u++) begin
        cq_d[s][u] = CONV_W'(gfpm_pkg::mod_steps(MODW'(cq_q[s-1][u]), p_eff,
                       CONV_W - 2 - s * CV_PER, CONV_W - 1 - (s + 1) * CV_PER));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_q <= cs_d;
      cq_q <= cq_d;
    end
  end

  for (genvar u = 0; u < Q; u++) begin : g_qin0
    assign qin[0][u] = CW'(cq_q[RED_ST-1][u]);
  end

  // Top-down folds with x^m = sum r_k x^k, one per fold block
  for (genvar f = 0; f < NFOLD; f++) begin : g_fold
    logic [FOLD_W-1:0] fz_d [FOLD_ST][Q];
    logic [FOLD_W-1:0] fz_q [FOLD_ST][Q];

    always_comb begin
      logic [CW-1:0]     lead;
      logic [PROD_W-1:0] prod;
      side_t             sd;
      sd   = sd_q[ST_F - 1 + FOLD_ST * f - ST_P];
      lead = qin[f][f];
      for (int u = 0; u < Q; u++) begin
        prod = '0;
        if (f + 2 <= int'(m_eff) && u > f && u - f <= N) begin
          prod = PROD_W'(lead) * PROD_W'(sd.rr[u-f-1]);
        end
        fz_d[0][u] = FOLD_W'(qin[f][u]) + FOLD_W'(prod);
      end
      for (int s = 1; s < FOLD_ST; s++) begin
        for (int u = 0; u < Q; u++) begin
          fz_d[s][u] = FOLD_W'(gfpm_pkg::mod_steps(MODW'(fz_q[s-1][u]), p_eff,
                         FOLD_W - 2 - (s - 1) * FD_PER, FOLD_W - 1 - s * FD_PER));
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        fz_q <= fz_d;
      end
    end

    for (genvar u = 0; u < Q; u++) begin : g_out
      assign qin[f+1][u] = CW'(fz_q[FOLD_ST-1][u]);
    end
  end

  // Output select and packing
  logic [WORD_W-1:0] result_d;
  logic [WORD_W-1:0] result_q;
  logic              equal_d;
  logic              equal_q;

  always_comb begin
    side_t         so;
    logic [CW-1:0] c;
    so       = sd_q[SD_N-1];
    result_d = '0;
    for (int k = 0; k < N; k++) begin
      c = '0;
      if (k < int'(m_eff)) begin
        if (so.mul) begin
          // undo the reversal: coefficient k sits at 2m-2-k
          for (int u = 0; u < Q; u++) begin
            if (u + k + 2 == 2 * int'(m_eff)) begin
              c = qin[N-1][u];
            end
          end
        end else begin
          c = so.early[k];
        end
      end
      result_d = result_d | (WORD_W'(DIGIT_BITS'(c)) << (DIGIT_BITS * k));
    end
    equal_d = so.eq;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q <= result_d;
      equal_q  <= equal_d;
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign result_o    = result_q;
  assign equal_o     = equal_q;

endmodule

`default_nettype wire

// File: sv/gfpm_checker.sv
// ----------------------------------------------------------------------------
// gfpm_checker
// Port-level checks for the GF(p^m) arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gf_pm_arithmetic_unit_assert.svh"

module gfpm_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [gfpm_pkg::WORD_W-1:0] result_o,
  input wire logic                        equal_o
);

  // Hold a stalled result.
  `GFPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(result_o) && $stable(equal_o), "stalled result changed")

  // Stall the input only behind a stalled result.
  `GFPM_ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without output stall")

  // Drain freely: a result taken leaves the input open.
  `GFPM_ASSERT_IMPLY(a_stall_free, clk_i, rst_ni, out_valid_o && !out_stall_i, !in_stall_o, "input stalled while result taken")

  // Compare results carry no element.
  `GFPM_ASSERT_IMPLY(a_equal_zero, clk_i, rst_ni, out_valid_o && equal_o, result_o == '0, "compare result with nonzero element")

endmodule

bind gf_pm_arithmetic_unit gfpm_checker u_gfpm_checker (.*);

`default_nettype wire
